// ----- src/smmc_pkg.sv -----
`timescale 1ns / 1ps

package smmc_pkg;

  // Shared SRAM geometry.
  localparam int SRAM_DEPTH = 8192;
  localparam int SRAM_AW    = $clog2(SRAM_DEPTH);

  // Access kinds carried with each input word.
  localparam logic [1:0] CMD_SUB_RD  = 2'd0;
  localparam logic [1:0] CMD_SUB_WR  = 2'd1;
  localparam logic [1:0] CMD_HOST_RD = 2'd2;
  localparam logic [1:0] CMD_HOST_WR = 2'd3;

  // ROM that supplies the data of a read.
  localparam logic [1:0] ROM_NONE  = 2'd0;
  localparam logic [1:0] ROM_MON   = 2'd1;
  localparam logic [1:0] ROM_DICT  = 2'd2;
  localparam logic [1:0] ROM_KANJI = 2'd3;

  // Host machine variants.
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_KANJI    = 2'd1;
  localparam logic [1:0] MODE_OTHER    = 2'd2;

  // Configuration register indexes (selected by address bit 2).
  localparam logic REG_CARD_ENABLE  = 1'b0;
  localparam logic REG_MACHINE_MODE = 1'b1;

  // Bus addresses.
  localparam logic [15:0] ADDR_BANK_REG  = 16'h9FFF;
  localparam logic [15:0] ADDR_HOST_SYNC = 16'hFD28;
  localparam logic [15:0] ADDR_HOST_MBOX = 16'hFD29;
  localparam logic [15:0] ADDR_HOST_KJ0  = 16'hFD2A;
  localparam logic [15:0] ADDR_HOST_KJ1  = 16'hFD2B;

  // Mailbox page: SRAM 0x1F00..0x1FFF.
  localparam logic [SRAM_AW-9:0] MBOX_PAGE = '1;

  typedef struct packed {
    logic       card_enable;
    logic [1:0] machine_mode;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ----- src/shared_sram_mailbox_card.sv -----
`timescale 1ns / 1ps
// A word accepted in the idle state is captured, reading the shared SRAM, and then
// committed: card state updates, the SRAM is written and the output register loads.
// The commit waits while an earlier result still sits unread in the output register.
// A new word is taken only after the last commits, even while its result still waits.
// Reset (rst_n, synchronous, active low) clears control, halt, bank, mailbox counter and
// kanji address and enables the card in mode 2; the 8K shared SRAM is not cleared.

module shared_sram_mailbox_card (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] addr, [23:16] wdata
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] rdata, [25:8] rom_addr, [31:26] zero
  output logic [2:0]  out_tuser,  // [1:0] rom_sel, [2] handled
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  smmc_pkg::cfg_t      cfg_r, cfg_nxt;
  smmc_pkg::ctrl_cmd_t cmd;

  logic        cfg_wr;
  logic [7:0]  rdata;
  logic [1:0]  rom_sel;
  logic [17:0] rom_addr;
  logic        handled;

  // The configuration port never stalls. Address bit 2 selects the register:
  // byte 0 holds card_enable, byte 4 holds machine_mode.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        smmc_pkg::REG_CARD_ENABLE:  cfg_nxt.card_enable  = cfg_pwdata[0];
        smmc_pkg::REG_MACHINE_MODE: cfg_nxt.machine_mode = cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.card_enable  <= 1'b1;
      cfg_r.machine_mode <= smmc_pkg::MODE_OTHER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      smmc_pkg::REG_CARD_ENABLE:  cfg_prdata = {31'b0, cfg_r.card_enable};
      smmc_pkg::REG_MACHINE_MODE: cfg_prdata = {30'b0, cfg_r.machine_mode};
      default:                    cfg_prdata = '0;
    endcase
  end

  // The controller sequences each word: capture (SRAM read), then commit
  // (state update, SRAM write and load of the result register).
  smmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // The datapath holds the shared SRAM, the card registers and the result.
  smmc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .in_cmd   (in_tuser),
    .in_addr  (in_tdata[15:0]),
    .in_wdata (in_tdata[23:16]),
    .rdata    (rdata),
    .rom_sel  (rom_sel),
    .rom_addr (rom_addr),
    .handled  (handled)
  );

  assign out_tdata = {6'b0, rom_addr, rdata};
  assign out_tuser = {handled, rom_sel};

endmodule

// ----- src/smmc_ctrl.sv -----
`timescale 1ns / 1ps

module smmc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output smmc_pkg::ctrl_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result slot is free, or is being emptied this cycle.
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  a_free_slot_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && !out_valid_r) |=> out_valid_r)
    else $error("free result slot was not loaded");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> !cmd.commit)
    else $error("capture and commit in the same cycle");

  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && state_r == ST_IDLE))
    else $error("commit did not present a result and return to idle");

endmodule

// ----- src/smmc_dp.sv -----
`timescale 1ns / 1ps

module smmc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smmc_pkg::ctrl_cmd_t  cmd,
  input  smmc_pkg::cfg_t       cfg,
  input  logic [1:0]           in_cmd,
  input  logic [15:0]          in_addr,
  input  logic [7:0]           in_wdata,
  output logic [7:0]           rdata,
  output logic [1:0]           rom_sel,
  output logic [17:0]          rom_addr,
  output logic                 handled
);

  localparam int AW = smmc_pkg::SRAM_AW;

  logic [7:0] mem_q [smmc_pkg::SRAM_DEPTH];

  // Captured access.
  logic [1:0]  cmd_r;
  logic [15:0] addr_r;
  logic [7:0]  wdata_r;
  logic [7:0]  rd_q_r;

  // Card state.
  logic        halt_r, halt_nxt;
  logic [5:0]  bank_r, bank_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] kanji_r, kanji_nxt;

  // Result registers.
  logic [7:0]  rdata_r, rdata_nxt;
  logic [1:0]  sel_r, sel_nxt;
  logic [17:0] raddr_r, raddr_nxt;
  logic        handled_r, handled_nxt;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          we;
  logic          host_en;
  logic          sram_hit;

  // The read address is chosen from the incoming word; the mailbox counter
  // cannot move before this access commits.
  assign rd_addr = (in_cmd == smmc_pkg::CMD_SUB_RD || in_cmd == smmc_pkg::CMD_SUB_WR)
                 ? in_addr[AW-1:0] : {smmc_pkg::MBOX_PAGE, cnt_r};

  assign host_en  = cfg.card_enable && (cfg.machine_mode != smmc_pkg::MODE_DISABLED);
  assign sram_hit = (addr_r[15:13] == 3'b100) && (addr_r != smmc_pkg::ADDR_BANK_REG);

  always_comb begin
    halt_nxt    = halt_r;
    bank_nxt    = bank_r;
    cnt_nxt     = cnt_r;
    kanji_nxt   = kanji_r;
    rdata_nxt   = 8'hFF;
    sel_nxt     = smmc_pkg::ROM_NONE;
    raddr_nxt   = '0;
    handled_nxt = 1'b0;
    we          = 1'b0;
    wr_addr     = {smmc_pkg::MBOX_PAGE, cnt_r};
    unique case (cmd_r)
      smmc_pkg::CMD_SUB_RD: begin
        if (addr_r[15:14] == 2'b11) begin
          sel_nxt   = smmc_pkg::ROM_MON;
          rdata_nxt = 8'h00;
          raddr_nxt = {4'b0000, addr_r[13:0]};
        end else if (addr_r[15:12] == 4'hA) begin
          sel_nxt   = smmc_pkg::ROM_DICT;
          rdata_nxt = 8'h00;
          raddr_nxt = {bank_r, addr_r[11:0]};
        end else if (sram_hit) begin
          rdata_nxt = rd_q_r;
        end else if (addr_r == smmc_pkg::ADDR_BANK_REG) begin
          rdata_nxt = {2'b00, bank_r};
        end
      end
      smmc_pkg::CMD_SUB_WR: begin
        rdata_nxt = 8'h00;
        if (addr_r == smmc_pkg::ADDR_BANK_REG) begin
          halt_nxt = ~wdata_r[7];
          bank_nxt = wdata_r[5:0];
        end else if (sram_hit) begin
          we      = 1'b1;
          wr_addr = addr_r[AW-1:0];
        end
      end
      smmc_pkg::CMD_HOST_RD: begin
        if (host_en) begin
          if (addr_r == smmc_pkg::ADDR_HOST_SYNC) begin
            handled_nxt = 1'b1;
            rdata_nxt   = halt_r ? 8'h7F : 8'hFF;
          end else if (addr_r == smmc_pkg::ADDR_HOST_MBOX) begin
            handled_nxt = 1'b1;
            if (halt_r) begin
              rdata_nxt = rd_q_r;
              cnt_nxt   = cnt_r + 8'd1;
            end
          end else if ((addr_r == smmc_pkg::ADDR_HOST_KJ0 ||
                        addr_r == smmc_pkg::ADDR_HOST_KJ1) &&
                       cfg.machine_mode == smmc_pkg::MODE_KANJI) begin
            handled_nxt = 1'b1;
            // Doubled address in 0x6000..0x7FFF is the undefined window.
            if (kanji_r[15:12] == 4'h3) begin
              rdata_nxt = {7'b0, addr_r[0]};
            end else begin
              sel_nxt   = smmc_pkg::ROM_KANJI;
              rdata_nxt = 8'h00;
              raddr_nxt = {1'b0, kanji_r, addr_r[0]};
            end
          end
        end
      end
      smmc_pkg::CMD_HOST_WR: begin
        if (host_en) begin
          priority if (addr_r == smmc_pkg::ADDR_HOST_SYNC) begin
            handled_nxt = 1'b1;
            kanji_nxt   = {wdata_r, kanji_r[7:0]};
          end else if (addr_r == smmc_pkg::ADDR_HOST_MBOX) begin
            handled_nxt = 1'b1;
            kanji_nxt   = {kanji_r[15:8], wdata_r};
          end else if (addr_r == smmc_pkg::ADDR_HOST_KJ0) begin
            handled_nxt = 1'b1;
            if (wdata_r[7]) begin
              halt_nxt = 1'b0;
            end else begin
              halt_nxt = 1'b1;
              cnt_nxt  = 8'd0;
            end
          end else if (addr_r == smmc_pkg::ADDR_HOST_KJ1) begin
            handled_nxt = 1'b1;
            if (halt_r) begin
              we      = 1'b1;
              cnt_nxt = cnt_r + 8'd1;
            end
          end else begin
            handled_nxt = 1'b0;
          end
          if (handled_nxt) begin
            rdata_nxt = 8'h00;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_addr;
      wdata_r <= in_wdata;
      rd_q_r  <= mem_q[rd_addr];
    end
    if (cmd.commit && we) begin
      mem_q[wr_addr] <= wdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rdata_r   <= rdata_nxt;
      sel_r     <= sel_nxt;
      raddr_r   <= raddr_nxt;
      handled_r <= handled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_r  <= 1'b0;
      bank_r  <= '0;
      cnt_r   <= '0;
      kanji_r <= '0;
    end else if (cmd.commit) begin
      halt_r  <= halt_nxt;
      bank_r  <= bank_nxt;
      cnt_r   <= cnt_nxt;
      kanji_r <= kanji_nxt;
    end
  end

  assign rdata    = rdata_r;
  assign rom_sel  = sel_r;
  assign rom_addr = raddr_r;
  assign handled  = handled_r;

endmodule
